/* design/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication
`define XCRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define XCRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* design/xcrc_pkg.sv */
package xcrc_pkg;
    localparam int PAYLOAD_BYTES = 128;
    localparam int DRAIN_LIMIT   = 2048;
    localparam int MAX_RES       = 5;

    localparam logic [2:0] K_SEND    = 3'd0;
    localparam logic [2:0] K_DATA    = 3'd1;
    localparam logic [2:0] K_COMMIT  = 3'd2;
    localparam logic [2:0] K_DISCARD = 3'd3;
    localparam logic [2:0] K_END     = 3'd4;

    localparam logic [7:0] B_SOH = 8'd1;
    localparam logic [7:0] B_EOT = 8'd4;
    localparam logic [7:0] B_ACK = 8'd6;
    localparam logic [7:0] B_NAK = 8'd21;
    localparam logic [7:0] B_CAN = 8'd24;
    localparam logic [7:0] B_C   = 8'd67;
    localparam logic [7:0] B_CR  = 8'd13;
    localparam logic [7:0] B_LF  = 8'd10;

    localparam logic [2:0] S_OK      = 3'd0;
    localparam logic [2:0] S_TIMEOUT = 3'd1;
    localparam logic [2:0] S_CANCEL  = 3'd2;
    localparam logic [2:0] S_DISC    = 3'd3;
    localparam logic [2:0] S_CRC     = 3'd4;
    localparam logic [2:0] S_PROTO   = 3'd5;
    localparam logic [2:0] S_WRITE   = 3'd6;

    localparam logic [2:0] C_START = 3'd0;
    localparam logic [2:0] C_BYTE  = 3'd1;
    localparam logic [2:0] C_TICK  = 3'd2;
    localparam logic [2:0] C_CANCEL = 3'd3;
    localparam logic [2:0] C_LINK  = 3'd4;
    localparam logic [2:0] C_FAULT = 3'd5;

    localparam logic [2:0] R_FIRST_WAIT = 3'd0;
    localparam logic [2:0] R_BLOCK_WAIT = 3'd1;
    localparam logic [2:0] R_BYTE_WAIT  = 3'd2;
    localparam logic [2:0] R_QUIET      = 3'd3;
    localparam logic [2:0] R_RETRY      = 3'd4;
    localparam logic [2:0] R_STARTUP    = 3'd5;
    localparam logic [2:0] R_TAIL       = 3'd6;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] status;
    } res_t;

    typedef struct packed {
        logic [2:0]       n;
        res_t [0:MAX_RES-1] e;
        logic [31:0]      count;
    } rlist_t;

    function automatic rlist_t push(rlist_t l, logic [2:0] k, logic [7:0] d, logic [2:0] s);
        rlist_t r;
        r = l;
        if (r.n < 3'(MAX_RES))
        begin
            r.e[r.n] = '{kind: k, data: d, status: s};
            r.n = r.n + 3'd1;
        end
        return r;
    endfunction

    function automatic rlist_t push_fail(rlist_t l, logic [2:0] s);
        rlist_t r;
        r = push(l, K_SEND, B_CAN, S_OK);
        r = push(r, K_SEND, B_CAN, S_OK);
        r = push(r, K_SEND, B_CAN, S_OK);
        r = push(r, K_END, 8'd0, s);
        return r;
    endfunction

    function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'd0};
        for (int i = 0; i < 8; i++)
            c = {c[14:0], 1'b0} ^ (c[15] ? 16'h1021 : 16'h0000);
        return c;
    endfunction
endpackage

/* design/xcrc_core.sv */
module xcrc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              acc,
    input  logic [2:0]        cmd,
    input  logic [7:0]        rx_byte,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output xcrc_pkg::rlist_t  res
);
    import xcrc_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_WAIT   = 5'b00010,
        PH_PACKET = 5'b00100,
        PH_DRAIN  = 5'b01000,
        PH_TAIL   = 5'b10000
    } phase_t;

    logic [15:0] first_wait_reg, block_wait_reg, byte_wait_reg, quiet_reg;
    logic [3:0]  retry_reg, tail_polls_reg;
    logic [5:0]  startup_lim_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  eseq_reg, eseq_next, pidx_reg, pidx_next, sb_reg, sb_next, scb_reg, scb_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [3:0]  err_reg, err_next, tail_reg, tail_next;
    logic [5:0]  sc_reg, sc_next;
    logic        started_reg, started_next, dh_reg, dh_next;
    logic [2:0]  le_reg, le_next;
    logic [15:0] crc_reg, crc_next, crcr_reg, crcr_next, tk_reg, tk_next, tk_inc;
    logic [11:0] dc_reg, dc_next;
    rlist_t      l;
    logic        err_path, err_hdr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_wait_reg  <= 16'd2000;
            block_wait_reg  <= 16'd3000;
            byte_wait_reg   <= 16'd1000;
            quiet_reg       <= 16'd100;
            retry_reg       <= 4'd10;
            startup_lim_reg <= 6'd30;
            tail_polls_reg  <= 4'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                R_FIRST_WAIT: first_wait_reg  <= cfg_data;
                R_BLOCK_WAIT: block_wait_reg  <= cfg_data;
                R_BYTE_WAIT:  byte_wait_reg   <= cfg_data;
                R_QUIET:      quiet_reg       <= cfg_data;
                R_RETRY:      retry_reg       <= cfg_data[3:0];
                R_STARTUP:    startup_lim_reg <= cfg_data[5:0];
                R_TAIL:       tail_polls_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign tk_inc = (tk_reg == 16'hFFFF) ? tk_reg : tk_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg; eseq_next = eseq_reg; cnt_next = cnt_reg;
        err_next = err_reg; sc_next = sc_reg; started_next = started_reg;
        dh_next = dh_reg; le_next = le_reg; pidx_next = pidx_reg; sb_next = sb_reg;
        scb_next = scb_reg; crc_next = crc_reg; crcr_next = crcr_reg; tk_next = tk_reg;
        dc_next = dc_reg; tail_next = tail_reg;
        l = '0;
        err_path = 1'b0;
        err_hdr = 1'b0;
        if (cmd <= C_FAULT)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (cmd == C_START)
                begin
                    eseq_next = 8'd1; cnt_next = '0; err_next = '0; sc_next = '0;
                    started_next = 1'b0; le_next = S_TIMEOUT; dh_next = 1'b0;
                    phase_next = PH_WAIT; tk_next = '0;
                    l = push(l, K_SEND, B_C, S_OK);
                end
            end
            else if (cmd == C_START)
            begin
                // ignore start while running
            end
            else if (phase_reg == PH_TAIL)
            begin
                if (cmd == C_BYTE)
                begin
                    tk_next = '0;
                    if (rx_byte == B_EOT)
                        l = push(l, K_SEND, B_ACK, S_OK);
                    tail_next = (tail_reg == 4'hF) ? tail_reg : tail_reg + 4'd1;
                    if (tail_next >= tail_polls_reg)
                    begin
                        l = push(l, K_END, 8'd0, S_OK);
                        phase_next = PH_IDLE;
                    end
                end
                else if (cmd == C_TICK)
                begin
                    tk_next = tk_inc;
                    if (tk_inc >= block_wait_reg)
                    begin
                        l = push(l, K_END, 8'd0, S_OK);
                        phase_next = PH_IDLE;
                    end
                end
                else if (cmd == C_CANCEL || cmd == C_LINK)
                begin
                    l = push(l, K_END, 8'd0, S_OK);
                    phase_next = PH_IDLE;
                end
            end
            else if (cmd >= C_CANCEL)
            begin
                if (phase_reg == PH_PACKET)
                    l = push(l, K_DISCARD, 8'd0, S_OK);
                l = push_fail(l, (cmd == C_CANCEL) ? S_CANCEL :
                                 (cmd == C_LINK) ? S_DISC : S_WRITE);
                phase_next = PH_IDLE;
            end
            else if (phase_reg == PH_WAIT)
            begin
                if (cmd == C_BYTE)
                begin
                    tk_next = '0;
                    if (rx_byte == B_CAN)
                    begin
                        l = push_fail(l, S_CANCEL);
                        phase_next = PH_IDLE;
                    end
                    else if (rx_byte == B_EOT)
                    begin
                        l = push(l, K_SEND, B_ACK, S_OK);
                        phase_next = PH_TAIL;
                        tail_next = '0;
                        if (tail_polls_reg == 4'd0)
                        begin
                            l = push(l, K_END, 8'd0, S_OK);
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (rx_byte == B_SOH)
                    begin
                        phase_next = PH_PACKET;
                        pidx_next = '0; crc_next = '0; crcr_next = '0;
                    end
                    else if (!started_reg && (rx_byte == B_CR || rx_byte == B_LF) &&
                             sc_reg < startup_lim_reg)
                    begin
                        sc_next = (sc_reg == 6'h3F) ? sc_reg : sc_reg + 6'd1;
                    end
                    else
                    begin
                        if (!started_reg && (rx_byte == B_CR || rx_byte == B_LF))
                            sc_next = (sc_reg == 6'h3F) ? sc_reg : sc_reg + 6'd1;
                        le_next = S_PROTO;
                        phase_next = PH_DRAIN; tk_next = '0; dc_next = '0; dh_next = 1'b0;
                    end
                end
                else
                begin
                    tk_next = tk_inc;
                    if (tk_inc >= (started_reg ? block_wait_reg : first_wait_reg))
                    begin
                        le_next = S_TIMEOUT;
                        if (!started_reg)
                        begin
                            sc_next = (sc_reg == 6'h3F) ? sc_reg : sc_reg + 6'd1;
                            if (sc_next >= startup_lim_reg)
                            begin
                                l = push_fail(l, S_TIMEOUT);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                l = push(l, K_SEND, B_C, S_OK);
                                phase_next = PH_WAIT; tk_next = '0;
                            end
                        end
                        else
                        begin
                            err_next = (err_reg == 4'hF) ? err_reg : err_reg + 4'd1;
                            if (err_next >= retry_reg)
                            begin
                                l = push_fail(l, S_TIMEOUT);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                l = push(l, K_SEND, B_NAK, S_OK);
                                phase_next = PH_WAIT; tk_next = '0;
                            end
                        end
                    end
                end
            end
            else if (phase_reg == PH_PACKET)
            begin
                if (cmd == C_BYTE)
                begin
                    tk_next = '0;
                    if (pidx_reg == 8'd0)
                        sb_next = rx_byte;
                    else if (pidx_reg == 8'd1)
                        scb_next = rx_byte;
                    else if (pidx_reg < 8'(2 + PAYLOAD_BYTES))
                    begin
                        l = push(l, K_DATA, rx_byte, S_OK);
                        crc_next = crc_step(crc_reg, rx_byte);
                    end
                    else if (pidx_reg == 8'(2 + PAYLOAD_BYTES))
                        crcr_next = {rx_byte, 8'd0};
                    else
                        crcr_next = crcr_reg | {8'd0, rx_byte};
                    pidx_next = pidx_reg + 8'd1;
                    if (pidx_reg >= 8'(3 + PAYLOAD_BYTES))
                    begin
                        if ((sb_next ^ scb_next) != 8'hFF)
                        begin
                            l = push(l, K_DISCARD, 8'd0, S_OK);
                            le_next = S_PROTO;
                            err_path = 1'b1; err_hdr = 1'b1;
                        end
                        else if (crc_next != crcr_next)
                        begin
                            l = push(l, K_DISCARD, 8'd0, S_OK);
                            le_next = S_CRC;
                            err_path = 1'b1; err_hdr = 1'b1;
                        end
                        else if (sb_next == eseq_reg)
                        begin
                            cnt_next = cnt_reg + 32'(PAYLOAD_BYTES);
                            eseq_next = eseq_reg + 8'd1;
                            started_next = 1'b1;
                            err_next = '0;
                            l = push(l, K_COMMIT, 8'd0, S_OK);
                            l = push(l, K_SEND, B_ACK, S_OK);
                            phase_next = PH_WAIT; tk_next = '0;
                        end
                        else if (started_reg && sb_next == eseq_reg - 8'd1)
                        begin
                            l = push(l, K_DISCARD, 8'd0, S_OK);
                            err_next = (err_reg == 4'hF) ? err_reg : err_reg + 4'd1;
                            if (err_next >= retry_reg)
                            begin
                                l = push_fail(l, S_PROTO);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                l = push(l, K_SEND, B_ACK, S_OK);
                                phase_next = PH_WAIT; tk_next = '0;
                            end
                        end
                        else
                        begin
                            l = push(l, K_DISCARD, 8'd0, S_OK);
                            l = push_fail(l, S_PROTO);
                            phase_next = PH_IDLE;
                        end
                    end
                end
                else
                begin
                    tk_next = tk_inc;
                    if (tk_inc >= byte_wait_reg)
                    begin
                        l = push(l, K_DISCARD, 8'd0, S_OK);
                        le_next = S_TIMEOUT;
                        phase_next = PH_DRAIN; tk_next = '0; dc_next = '0; dh_next = 1'b1;
                    end
                end
            end
            else if (phase_reg == PH_DRAIN)
            begin
                err_hdr = dh_reg;
                if (cmd == C_BYTE)
                begin
                    tk_next = '0;
                    if ({1'b0, dc_reg} + 13'd1 >= 13'(DRAIN_LIMIT))
                        err_path = 1'b1;
                    else
                        dc_next = dc_reg + 12'd1;
                end
                else
                begin
                    tk_next = tk_inc;
                    if (tk_inc >= quiet_reg)
                        err_path = 1'b1;
                end
            end
            else
            begin
                phase_next = PH_IDLE;
            end

            // shared retry handling after a bad packet or a finished drain
            if (err_path)
            begin
                err_next = (err_reg == 4'hF) ? err_reg : err_reg + 4'd1;
                if (err_next >= retry_reg)
                begin
                    l = push_fail(l, le_next);
                    phase_next = PH_IDLE;
                end
                else
                begin
                    l = push(l, K_SEND, (started_reg || err_hdr) ? B_NAK : B_C, S_OK);
                    phase_next = PH_WAIT; tk_next = '0;
                end
            end
        end
        l.count = cnt_next;
    end

    assign res = l;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; eseq_reg <= 8'd1; cnt_reg <= '0; err_reg <= '0;
            sc_reg <= '0; started_reg <= 1'b0; dh_reg <= 1'b0; le_reg <= S_TIMEOUT;
            pidx_reg <= '0; sb_reg <= '0; scb_reg <= '0; crc_reg <= '0; crcr_reg <= '0;
            tk_reg <= '0; dc_reg <= '0; tail_reg <= '0;
        end
        else if (acc)
        begin
            phase_reg <= phase_next; eseq_reg <= eseq_next; cnt_reg <= cnt_next;
            err_reg <= err_next; sc_reg <= sc_next; started_reg <= started_next;
            dh_reg <= dh_next; le_reg <= le_next; pidx_reg <= pidx_next; sb_reg <= sb_next;
            scb_reg <= scb_next; crc_reg <= crc_next; crcr_reg <= crcr_next;
            tk_reg <= tk_next; dc_reg <= dc_next; tail_reg <= tail_next;
        end
    end
endmodule

/* design/xcrc_outbuf.sv */
module xcrc_outbuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             acc,
    input  xcrc_pkg::rlist_t res,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       out_kind,
    output logic [7:0]       out_byte,
    output logic [2:0]       status,
    output logic [31:0]      byte_count,
    output logic             last
);
    import xcrc_pkg::*;

    res_t [0:MAX_RES-1] ent_reg;
    logic [31:0]        count_reg;
    logic [2:0]         n_reg, idx_reg;
    logic               fin;

    assign out_valid  = (n_reg != 3'd0);
    assign last       = (idx_reg == n_reg - 3'd1);
    assign fin        = out_valid && out_ready && last;
    assign room       = !out_valid || fin;
    assign out_kind   = ent_reg[idx_reg].kind;
    assign out_byte   = ent_reg[idx_reg].data;
    assign status     = ent_reg[idx_reg].status;
    assign byte_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= '0;
            idx_reg <= '0;
        end
        else if (acc)
        begin
            n_reg   <= res.n;
            idx_reg <= '0;
        end
        else if (fin)
        begin
            n_reg   <= '0;
            idx_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // payload holds, no reset
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            ent_reg   <= res.e;
            count_reg <= res.count;
        end
    end
endmodule

/* design/xmodem_crc_receiver_top.sv */
// XMODEM-CRC receiver: one event item accepted per cycle while the result buffer is free.
// Results of an item appear in the cycle after it is accepted.
// An item producing k results (0..5) holds the output until all k have been taken;
//   the next item is taken in the cycle the final result leaves.
// Reset (rst_n low, asynchronous): idle phase, registers to their defaults, buffer empty.
module xmodem_crc_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic [2:0]  status,
    output logic [31:0] byte_count,
    output logic        last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import xcrc_pkg::*;

    rlist_t res;
    logic   room, acc;

    assign in_ready = room;
    assign acc      = in_valid && room;

    xcrc_core u_core (
        .clk(clk), .rst_n(rst_n), .acc(acc), .cmd(cmd), .rx_byte(rx_byte),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .res(res)
    );

    xcrc_outbuf u_buf (
        .clk(clk), .rst_n(rst_n), .acc(acc), .res(res), .room(room),
        .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
        .out_byte(out_byte), .status(status), .byte_count(byte_count), .last(last)
    );
endmodule

/* design/xcrc_checker.sv */
`include "assert_macros.svh"
module xcrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_kind,
    input logic [7:0]  out_byte,
    input logic [2:0]  status,
    input logic        last
);
    import xcrc_pkg::*;

    logic stalled, verdict_kind;

    assign stalled      = out_valid && !out_ready;
    assign verdict_kind = (out_kind == K_COMMIT || out_kind == K_DISCARD || out_kind == K_END);

    `XCRC_ASSERT_NEXT(a_hold_kind, stalled, out_valid && $stable(out_kind))
    `XCRC_ASSERT_NEXT(a_hold_byte, stalled, out_valid && $stable(out_byte))
    `XCRC_ASSERT_NOW(a_end_last, out_valid && out_kind == K_END, last)
    `XCRC_ASSERT_NOW(a_status_zero, out_valid && out_kind != K_END, status == S_OK)
    `XCRC_ASSERT_NOW(a_byte_zero, out_valid && verdict_kind, out_byte == 8'd0)
endmodule

bind xmodem_crc_receiver_top xcrc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_byte(out_byte), .status(status), .last(last)
);

/* tb/tb_xmodem_crc_receiver_top.sv */
`timescale 1ns / 100ps

module tb_xmodem_crc_receiver_top;
    import xcrc_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_WAIT   = 5'b00010,
        PH_PACKET = 5'b00100,
        PH_DRAIN  = 5'b01000,
        PH_TAIL   = 5'b10000
    } phase_e;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [2:0]  st;
        logic [31:0] count;
        logic        last;
    } result_t;

    typedef struct {
        logic [2:0] c;
        logic [7:0] b;
        bit         typed;
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] st;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  cmd = 3'd0;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  out_kind;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic [31:0] byte_count;
    logic        last;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data = 16'd0;

    xmodem_crc_receiver_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
        .out_byte(out_byte), .status(status), .byte_count(byte_count), .last(last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver-side copy of the block state
    int          first_wait, block_wait, byte_wait, quiet, retry_lim, startup_lim, tail_lim;
    phase_e      ph;
    logic [7:0]  want_seq;
    logic [31:0] committed;
    int          errs, startups, pkt_idx, ticks, drains, tails;
    bit          started, drain_hdr;
    logic [2:0]  last_err;
    logic [7:0]  seq_b, seq_chk;
    logic [15:0] crc_run, crc_rcv;

    result_t step_res[$];
    result_t pending_q[$];
    int      n_errors = 0;
    int      n_items = 0;
    int      n_checked = 0;
    int      n_commits = 0;
    int      burst_left = 0;

    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        repeat (8)
            r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
        return r;
    endfunction

    task automatic emit(logic [2:0] k, logic [7:0] d, logic [2:0] s);
        result_t r;
        r.kind = k; r.data = d; r.st = s; r.count = committed; r.last = 1'b0;
        if (step_res.size() < MAX_RES)
            step_res.push_back(r);
    endtask

    task automatic abort_xfer(logic [2:0] s);
        emit(K_SEND, B_CAN, S_OK);
        emit(K_SEND, B_CAN, S_OK);
        emit(K_SEND, B_CAN, S_OK);
        emit(K_END, 8'd0, s);
        ph = PH_IDLE;
    endtask

    task automatic go_wait();
        ph = PH_WAIT;
        ticks = 0;
    endtask

    task automatic begin_drain(bit from_hdr);
        ph = PH_DRAIN;
        ticks = 0;
        drains = 0;
        drain_hdr = from_hdr;
    endtask

    task automatic count_err();
        if (errs < 15) errs++;
    endtask

    task automatic nak_or_abort(bit from_hdr);
        count_err();
        if (errs >= retry_lim)
        begin
            abort_xfer(last_err);
            return;
        end
        emit(K_SEND, (started || from_hdr) ? B_NAK : B_C, S_OK);
        go_wait();
    endtask

    task automatic header_timeout();
        last_err = S_TIMEOUT;
        if (!started)
        begin
            if (startups < 63) startups++;
            if (startups >= startup_lim)
            begin
                abort_xfer(last_err);
                return;
            end
        end
        else
        begin
            count_err();
            if (errs >= retry_lim)
            begin
                abort_xfer(last_err);
                return;
            end
        end
        emit(K_SEND, started ? B_NAK : B_C, S_OK);
        go_wait();
    endtask

    function automatic bit tick_hit(int lim);
        if (ticks < 16'hFFFF) ticks++;
        return ticks >= lim;
    endfunction

    task automatic close_packet();
        if ((seq_b ^ seq_chk) != 8'hFF)
        begin
            emit(K_DISCARD, 8'd0, S_OK);
            last_err = S_PROTO;
            nak_or_abort(1'b1);
        end
        else if (crc_run != crc_rcv)
        begin
            emit(K_DISCARD, 8'd0, S_OK);
            last_err = S_CRC;
            nak_or_abort(1'b1);
        end
        else if (seq_b == want_seq)
        begin
            committed = committed + PAYLOAD_BYTES;
            want_seq = want_seq + 8'd1;
            started = 1'b1;
            errs = 0;
            n_commits++;
            emit(K_COMMIT, 8'd0, S_OK);
            emit(K_SEND, B_ACK, S_OK);
            go_wait();
        end
        else if (started && seq_b == want_seq - 8'd1)
        begin
            emit(K_DISCARD, 8'd0, S_OK);
            count_err();
            if (errs >= retry_lim)
            begin
                abort_xfer(S_PROTO);
                return;
            end
            emit(K_SEND, B_ACK, S_OK);
            go_wait();
        end
        else
        begin
            emit(K_DISCARD, 8'd0, S_OK);
            abort_xfer(S_PROTO);
        end
    endtask

    task automatic packet_byte(logic [7:0] b);
        int i;
        i = pkt_idx;
        ticks = 0;
        if (i == 0) seq_b = b;
        else if (i == 1) seq_chk = b;
        else if (i < 2 + PAYLOAD_BYTES)
        begin
            emit(K_DATA, b, S_OK);
            crc_run = crc16_update(crc_run, b);
        end
        else if (i == 2 + PAYLOAD_BYTES) crc_rcv = {b, 8'h00};
        else crc_rcv[7:0] = b;
        pkt_idx = (i + 1) % 256;
        if (i >= 3 + PAYLOAD_BYTES) close_packet();
    endtask

    task automatic header_byte(logic [7:0] b);
        bit room;
        ticks = 0;
        if (b == B_CAN)
        begin
            abort_xfer(S_CANCEL);
            return;
        end
        if (b == B_EOT)
        begin
            emit(K_SEND, B_ACK, S_OK);
            ph = PH_TAIL;
            tails = 0;
            if (tail_lim == 0)
            begin
                emit(K_END, 8'd0, S_OK);
                ph = PH_IDLE;
            end
            return;
        end
        if (b == B_SOH)
        begin
            ph = PH_PACKET;
            pkt_idx = 0;
            crc_run = 16'h0000;
            crc_rcv = 16'h0000;
            return;
        end
        if (!started && (b == B_CR || b == B_LF))
        begin
            room = startups < startup_lim;
            if (startups < 63) startups++;
            if (room) return;
        end
        last_err = S_PROTO;
        begin_drain(1'b0);
    endtask

    task automatic predict(logic [2:0] c, logic [7:0] b);
        step_res.delete();
        if (c > C_FAULT)
            ;
        else if (ph == PH_IDLE)
        begin
            if (c == C_START)
            begin
                want_seq = 8'd1; committed = '0; errs = 0; startups = 0;
                started = 1'b0; last_err = S_TIMEOUT; drain_hdr = 1'b0;
                go_wait();
                emit(K_SEND, B_C, S_OK);
            end
        end
        else if (c == C_START)
            ;
        else if (ph == PH_TAIL)
        begin
            if (c == C_BYTE)
            begin
                ticks = 0;
                if (b == B_EOT) emit(K_SEND, B_ACK, S_OK);
                if (tails < 15) tails++;
                if (tails >= tail_lim)
                begin
                    emit(K_END, 8'd0, S_OK);
                    ph = PH_IDLE;
                end
            end
            else if ((c == C_TICK && tick_hit(block_wait)) || c == C_CANCEL || c == C_LINK)
            begin
                emit(K_END, 8'd0, S_OK);
                ph = PH_IDLE;
            end
        end
        else if (c >= C_CANCEL)
        begin
            if (ph == PH_PACKET) emit(K_DISCARD, 8'd0, S_OK);
            abort_xfer(c == C_CANCEL ? S_CANCEL : c == C_LINK ? S_DISC : S_WRITE);
        end
        else if (ph == PH_WAIT)
        begin
            if (c == C_BYTE) header_byte(b);
            else if (tick_hit(started ? block_wait : first_wait)) header_timeout();
        end
        else if (ph == PH_PACKET)
        begin
            if (c == C_BYTE) packet_byte(b);
            else if (tick_hit(byte_wait))
            begin
                emit(K_DISCARD, 8'd0, S_OK);
                last_err = S_TIMEOUT;
                begin_drain(1'b1);
            end
        end
        else
        begin
            if (c == C_BYTE)
            begin
                ticks = 0;
                if (drains + 1 >= DRAIN_LIMIT) nak_or_abort(drain_hdr);
                else drains++;
            end
            else if (tick_hit(quiet))
                nak_or_abort(drain_hdr);
        end
    endtask

    // drive one item, wait for it to be taken, then predict its results
    task automatic put(logic [2:0] c, logic [7:0] b, bit typed = 1'b0,
                       logic [2:0] k = K_SEND, logic [7:0] d = 8'd0, logic [2:0] s = S_OK);
        int gap;
        result_t r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= c;
        rx_byte <= b;
        do @(posedge clk); while (!in_ready);
        n_items++;
        predict(c, b);
        if (typed)
        begin
            step_res.delete();
            r.kind = k; r.data = d; r.st = s; r.count = committed; r.last = 1'b0;
            step_res.push_back(r);
        end
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[i])
            pending_q.push_back(step_res[i]);
    endtask

    // hold the sender until every pending result has drained
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes; the caller drops it
    task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            R_FIRST_WAIT: first_wait = val;
            R_BLOCK_WAIT: block_wait = val;
            R_BYTE_WAIT:  byte_wait = val;
            R_QUIET:      quiet = val;
            R_RETRY:      retry_lim = val[3:0];
            R_STARTUP:    startup_lim = val[5:0];
            R_TAIL:       tail_lim = val[3:0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(int fw, int bw, int yw, int qt, int rl, int sl, int tp);
        settle();
        cfg_write(R_FIRST_WAIT, 16'(fw));
        cfg_write(R_BLOCK_WAIT, 16'(bw));
        cfg_write(R_BYTE_WAIT, 16'(yw));
        cfg_write(R_QUIET, 16'(qt));
        cfg_write(R_RETRY, 16'(rl));
        cfg_write(R_STARTUP, 16'(sl));
        cfg_write(R_TAIL, 16'(tp));
        cfg_we <= 1'b0;
    endtask

    // flavor: 0 good, 1 bad crc, 2 bad complement, 3 duplicate, 4 wrong seq, 5 cut short
    task automatic send_packet(int flavor);
        logic [7:0]  sq;
        logic [7:0]  d;
        logic [15:0] crc;
        int          n;
        sq = want_seq;
        if (flavor == 3) sq = want_seq - 8'd1;
        if (flavor == 4) sq = want_seq + 8'd1 + 8'($urandom_range(1, 250));
        n = (flavor == 5) ? $urandom_range(1, 12) : PAYLOAD_BYTES + 4;
        crc = 16'h0000;
        put(C_BYTE, B_SOH);
        put(C_BYTE, sq);
        if (n == 1) return;
        put(C_BYTE, flavor == 2 ? sq ^ 8'h7F : ~sq);
        for (int i = 0; i < PAYLOAD_BYTES && i + 2 < n; i++)
        begin
            d = $urandom_range(0, 255);
            crc = crc16_update(crc, d);
            put(C_BYTE, d);
        end
        if (n < PAYLOAD_BYTES + 4)
        begin
            repeat ($urandom_range(1, 4)) put(C_TICK, 8'($urandom));
            return;
        end
        if (flavor == 1) crc = crc ^ (16'h1 << $urandom_range(0, 15));
        put(C_BYTE, crc[15:8]);
        put(C_BYTE, crc[7:0]);
    endtask

    // apart from the lead packet, full packets only while the budget still has room for one
    task automatic random_part(int budget, bit lead_packet);
        int  stop, r;
        bit  fits;
        stop = n_items + budget;
        if (lead_packet)
        begin
            if (ph == PH_IDLE) put(C_START, 8'($urandom));
            if (ph == PH_WAIT) send_packet(0);
        end
        while (n_items < stop)
        begin
            r = $urandom_range(0, 15);
            if (ph == PH_IDLE && r < 14 && $urandom_range(0, 7) != 0)
                put(C_START, 8'($urandom));
            fits = (stop - n_items) >= PAYLOAD_BYTES + 4;
            case (r)
                0, 1:  if (fits && ph == PH_WAIT && $urandom_range(0, 2) == 0) send_packet(0);
                       else send_packet(5);
                2:     send_packet(fits ? $urandom_range(1, 5) : 5);
                3:     send_packet(fits ? 3 : 5);
                4:
                begin
                    put(C_BYTE, B_EOT);
                    repeat ($urandom_range(0, 4))
                        put(C_BYTE, $urandom_range(0, 1) ? B_EOT : 8'($urandom));
                end
                5, 6:  repeat ($urandom_range(1, 6)) put(C_TICK, 8'($urandom));
                7:
                begin
                    put(C_BYTE, 8'($urandom_range(32, 255)));
                    repeat ($urandom_range(0, 3)) put(C_BYTE, 8'($urandom));
                    repeat ($urandom_range(0, 4)) put(C_TICK, 8'($urandom));
                end
                8:     put(C_BYTE, $urandom_range(0, 1) ? B_CR : B_LF);
                9:     put(3'($urandom_range(C_CANCEL, C_FAULT)), 8'($urandom));
                10:    put(C_BYTE, B_CAN);
                11:    put(C_START, 8'($urandom));
                12:    put(3'($urandom_range(6, 7)), 8'($urandom));
                default: put(3'($urandom_range(0, 7)), 8'($urandom));
            endcase
        end
    endtask

    row_t dir_rows[] = '{
        '{C_TICK,   8'hFF, 1'b0, K_SEND,  8'h00,  S_OK},
        '{C_BYTE,   8'h00, 1'b0, K_SEND,  8'h00,  S_OK},
        '{3'd6,     8'hA5, 1'b0, K_SEND,  8'h00,  S_OK},
        '{C_START,  8'h00, 1'b1, K_SEND,  B_C,    S_OK},
        '{C_START,  8'h00, 1'b0, K_SEND,  8'h00,  S_OK},
        '{C_BYTE,   B_CR,  1'b0, K_SEND,  8'h00,  S_OK},
        '{C_BYTE,   B_LF,  1'b0, K_SEND,  8'h00,  S_OK},
        '{C_BYTE,   8'hFF, 1'b0, K_SEND,  8'h00,  S_OK},
        '{C_BYTE,   8'h00, 1'b0, K_SEND,  8'h00,  S_OK},
        '{C_CANCEL, 8'h00, 1'b0, K_SEND,  8'h00,  S_OK},
        '{C_START,  8'hFF, 1'b1, K_SEND,  B_C,    S_OK},
        '{C_BYTE,   B_EOT, 1'b1, K_SEND,  B_ACK,  S_OK},
        '{C_BYTE,   B_EOT, 1'b1, K_SEND,  B_ACK,  S_OK},
        '{C_LINK,   8'h00, 1'b1, K_END,   8'h00,  S_OK},
        '{C_START,  8'h00, 1'b1, K_SEND,  B_C,    S_OK},
        '{C_BYTE,   B_CAN, 1'b0, K_SEND,  8'h00,  S_OK},
        '{C_START,  8'h00, 1'b1, K_SEND,  B_C,    S_OK},
        '{C_FAULT,  8'h00, 1'b0, K_SEND,  8'h00,  S_OK},
        '{C_START,  8'h00, 1'b1, K_SEND,  B_C,    S_OK},
        '{C_BYTE,   B_SOH, 1'b0, K_SEND,  8'h00,  S_OK},
        '{C_BYTE,   8'h01, 1'b0, K_SEND,  8'h00,  S_OK},
        '{C_BYTE,   8'hFE, 1'b0, K_SEND,  8'h00,  S_OK},
        '{C_BYTE,   8'h00, 1'b1, K_DATA,  8'h00,  S_OK},
        '{C_BYTE,   8'hFF, 1'b1, K_DATA,  8'hFF,  S_OK},
        '{C_CANCEL, 8'h00, 1'b0, K_SEND,  8'h00,  S_OK}
    };

    // receiver stall pattern: long stretches of one behavior each
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 80);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && out_valid && out_ready)
        begin
            n_checked++;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result kind=%0d byte=%0d", out_kind, out_byte);
                n_errors++;
            end
            else
            begin
                w = pending_q.pop_front();
                if (out_kind !== w.kind)
                begin
                    $error("out_kind: expected %0d, got %0d", w.kind, out_kind);
                    n_errors++;
                end
                if (out_byte !== w.data)
                begin
                    $error("out_byte: expected %0d, got %0d", w.data, out_byte);
                    n_errors++;
                end
                if (status !== w.st)
                begin
                    $error("status: expected %0d, got %0d", w.st, status);
                    n_errors++;
                end
                if (byte_count !== w.count)
                begin
                    $error("byte_count: expected %0d, got %0d", w.count, byte_count);
                    n_errors++;
                end
                if (last !== w.last)
                begin
                    $error("last: expected %0d, got %0d", w.last, last);
                    n_errors++;
                end
            end
        end
    end

    // abort if neither channel moves for too long
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000)
        begin
            $display("tb_xmodem_crc_receiver_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        first_wait = 2000; block_wait = 3000; byte_wait = 1000; quiet = 100;
        retry_lim = 10; startup_lim = 30; tail_lim = 10;
        ph = PH_IDLE; want_seq = 8'd1; committed = '0; errs = 0; startups = 0;
        started = 1'b0; drain_hdr = 1'b0; last_err = S_TIMEOUT; pkt_idx = 0;
        seq_b = '0; seq_chk = '0; crc_run = '0; crc_rcv = '0; ticks = 0;
        drains = 0; tails = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            put(dir_rows[i].c, dir_rows[i].b, dir_rows[i].typed,
                dir_rows[i].kind, dir_rows[i].data, dir_rows[i].st);

        // short timeouts so that every timeout path fires
        cfg_all(3, 4, 2, 2, 3, 2, 2);
        random_part(150, 1'b1);
        cfg_all(1, 1, 1, 1, 1, 1, 0);
        random_part(50, 1'b0);
        cfg_all(65535, 65535, 65535, 65535, 15, 63, 15);
        random_part(50, 1'b0);
        cfg_all(5, 3, 4, 3, 2, 4, 3);
        random_part(40, 1'b0);

        settle();
        repeat (10) @(posedge clk);
        $display("covered %0d items, %0d results checked, %0d packets committed",
                 n_items, n_checked, n_commits);
        $display("settings walked: defaults, short timeouts, all minimum, all maximum");
        if (n_errors == 0)
            $display("tb_xmodem_crc_receiver_top OK");
        else
            $display("tb_xmodem_crc_receiver_top NOT OK");
        $finish;
    end
endmodule

/* files.f */
+incdir+design
design/xcrc_pkg.sv
design/xcrc_core.sv
design/xcrc_outbuf.sv
design/xmodem_crc_receiver_top.sv
design/xcrc_checker.sv
tb/tb_xmodem_crc_receiver_top.sv
